// File: rtl/core/skx_pkg.sv
// shared types, constants and codes for the salsa keystream byte xor unit
package skx_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned WORD_IDX_W  = 4;
    localparam int unsigned BLK_IDX_W   = 26;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned HALF_CNT_W  = 5;
    localparam int unsigned STEP_W      = 2;

    // 10 double rounds, two half rounds each
    localparam logic [HALF_CNT_W-1:0] LAST_HALF = HALF_CNT_W'(19);
    localparam logic [STEP_W-1:0]     LAST_STEP = '1;

    // diagonal constants, little-endian words of "jkgh", "bzsi", "ot[a", "12aw"
    localparam logic [WORD_W-1:0] DIAG_C0 = 32'h6867_6B6A;
    localparam logic [WORD_W-1:0] DIAG_C1 = 32'h6973_7A62;
    localparam logic [WORD_W-1:0] DIAG_C2 = 32'h615B_746F;
    localparam logic [WORD_W-1:0] DIAG_C3 = 32'h7761_3231;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_PREFIX = 2'd2;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } skx_core_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_GEN
    } skx_top_state_t;

    typedef struct packed {
        logic                 start;
        logic [BLK_IDX_W-1:0] blk_idx;
    } skx_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } skx_sts_t;

endpackage

// File: rtl/core/salsa_keystream_byte_xor_unit.sv
// top level: byte xor with a cached salsa keystream block
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+----------------
//  input    | s_data_in, s_byte_position, s_last_in         | s_valid/s_ready
//  result   | m_data_out, m_last_out                        | m_valid/m_ready
//  config   | cfg_index, cfg_data                           | cfg_we, no wait
//
// a byte whose block is cached is answered in the cycle after its transaction
// a block change takes one load, 80 column steps (4 per half round), the final add
// over the shared adders row by row, then done is registered and the result register is loaded
// s_ready is low while a block is generated and while an unread result is stalled
// reset empties the cache, so the first byte always generates a block
module salsa_keystream_byte_xor_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [skx_pkg::DATA_W-1:0]         s_data_in,
    input  logic [skx_pkg::POS_W-1:0]          s_byte_position,
    input  logic                               s_last_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [skx_pkg::DATA_W-1:0]         m_data_out,
    output logic                               m_last_out,
    input  logic                               cfg_we,
    input  logic [skx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [skx_pkg::CFG_W-1:0]          cfg_data
);
    import skx_pkg::*;

    skx_top_state_t        state_reg, state_next;
    logic [CFG_W-1:0]      key_low_reg, key_high_reg, nonce_prefix_reg;
    logic [BLK_IDX_W-1:0]  cached_idx_reg, cached_idx_next;
    logic                  blk_valid_reg, blk_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]     m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;
    logic [DATA_W-1:0]     pend_data_reg, pend_data_next;
    logic [5:0]            pend_off_reg, pend_off_next;
    logic                  pend_last_reg, pend_last_next;

    skx_ctl_t              core_ctl;
    skx_sts_t              core_sts;
    logic [WORD_IDX_W-1:0] rd_idx;
    logic [WORD_W-1:0]     rd_word;
    logic [5:0]            rd_off;
    logic [DATA_W-1:0]     ks_byte;
    logic [BLK_IDX_W-1:0]  s_blk;
    logic                  s_fire;
    logic                  hit;

    skx_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (core_ctl),
        .key_low      (key_low_reg),
        .key_high     (key_high_reg),
        .nonce_prefix (nonce_prefix_reg),
        .rd_idx       (rd_idx),
        .rd_word      (rd_word),
        .sts          (core_sts)
    );

    assign s_blk      = s_byte_position[POS_W-1:6];
    assign s_ready    = (state_reg == TOP_IDLE) && !core_sts.busy
                        && (!m_valid_reg || m_ready);
    assign s_fire     = s_valid && s_ready;
    assign hit        = blk_valid_reg && (s_blk == cached_idx_reg);
    assign rd_off     = (state_reg == TOP_GEN) ? pend_off_reg : s_byte_position[5:0];
    assign rd_idx     = rd_off[5:2];
    assign ks_byte    = rd_word[{rd_off[1:0], 3'b000} +: DATA_W];
    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;
    assign m_last_out = m_last_reg;

    always_comb begin
        state_next       = state_reg;
        cached_idx_next  = cached_idx_reg;
        blk_valid_next   = blk_valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        pend_data_next   = pend_data_reg;
        pend_off_next    = pend_off_reg;
        pend_last_next   = pend_last_reg;
        core_ctl.start   = 1'b0;
        core_ctl.blk_idx = s_blk;
        case (state_reg)
            TOP_IDLE: begin
                if (s_fire) begin
                    if (hit) begin
                        m_valid_next = 1'b1;
                        m_data_next  = s_data_in ^ ks_byte;
                        m_last_next  = s_last_in;
                    end else begin
                        // cache is rebuilt: invalid until the block is finished
                        core_ctl.start  = 1'b1;
                        cached_idx_next = s_blk;
                        blk_valid_next  = 1'b0;
                        pend_data_next  = s_data_in;
                        pend_off_next   = s_byte_position[5:0];
                        pend_last_next  = s_last_in;
                        state_next      = TOP_GEN;
                    end
                end
            end
            TOP_GEN: begin
                if (core_sts.done) begin
                    blk_valid_next = 1'b1;
                    m_valid_next   = 1'b1;
                    m_data_next    = pend_data_reg ^ ks_byte;
                    m_last_next    = pend_last_reg;
                    state_next     = TOP_IDLE;
                end
            end
            default: begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= TOP_IDLE;
            cached_idx_reg   <= '0;
            blk_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
            key_low_reg      <= '0;
            key_high_reg     <= '0;
            nonce_prefix_reg <= '0;
        end else begin
            state_reg      <= state_next;
            cached_idx_reg <= cached_idx_next;
            blk_valid_reg  <= blk_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KEY_LOW:      key_low_reg      <= cfg_data;
                    CFG_KEY_HIGH:     key_high_reg     <= cfg_data;
                    CFG_NONCE_PREFIX: nonce_prefix_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        pend_data_reg <= pend_data_next;
        pend_off_reg  <= pend_off_next;
        pend_last_reg <= pend_last_next;
    end

endmodule

// File: rtl/core/skx_core.sv
// salsa block generator: one column step unit reused over all rounds, block held as 16 words
module skx_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  skx_pkg::skx_ctl_t                  ctl,
    input  logic [skx_pkg::CFG_W-1:0]          key_low,
    input  logic [skx_pkg::CFG_W-1:0]          key_high,
    input  logic [skx_pkg::CFG_W-1:0]          nonce_prefix,
    input  logic [skx_pkg::WORD_IDX_W-1:0]     rd_idx,
    output logic [skx_pkg::WORD_W-1:0]         rd_word,
    output skx_pkg::skx_sts_t                  sts
);
    import skx_pkg::*;

    skx_core_state_t         state_reg, state_next;
    logic [HALF_CNT_W-1:0]   half_reg, half_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [BLK_IDX_W-1:0]    blk_reg, blk_next;
    logic                    done_reg, done_next;
    logic [WORD_W-1:0]       st_reg [NUM_WORDS];
    logic [WORD_W-1:0]       st_next [NUM_WORDS];

    logic [BLK_IDX_W-1:0]    blk_src;
    logic [WORD_W-1:0]       init_w [NUM_WORDS];
    logic [WORD_W-1:0]       stepped [NUM_WORDS];
    logic [WORD_W-1:0]       op_a [4];
    logic [WORD_W-1:0]       op_b [4];
    logic [WORD_W-1:0]       sum [4];

    // position k of the quad that starts on diagonal j
    function automatic logic [WORD_IDX_W-1:0] quad_idx(input int j, input int k);
        return WORD_IDX_W'((5 * j + 4 * k) % 16);
    endfunction

    function automatic logic [WORD_W-1:0] qr_rot(input logic [WORD_W-1:0] v,
                                                 input logic [STEP_W-1:0] step);
        logic [WORD_W-1:0] r;
        case (step)
            2'd0:    r = {v[24:0], v[31:25]};
            2'd1:    r = {v[22:0], v[31:23]};
            2'd2:    r = {v[18:0], v[31:19]};
            default: r = {v[13:0], v[31:14]};
        endcase
        return r;
    endfunction

    assign rd_word  = st_reg[rd_idx];
    assign sts.busy = (state_reg != CORE_IDLE);
    assign sts.done = done_reg;

    always_comb begin
        blk_src = (state_reg == CORE_IDLE) ? ctl.blk_idx : blk_reg;
        init_w[0]  = DIAG_C0;
        init_w[1]  = key_low[31:0];
        init_w[2]  = key_low[63:32];
        init_w[3]  = key_high[31:0];
        init_w[4]  = key_high[63:32];
        init_w[5]  = DIAG_C1;
        init_w[6]  = nonce_prefix[31:0];
        init_w[7]  = nonce_prefix[63:32];
        init_w[8]  = {{(WORD_W - BLK_IDX_W){1'b0}}, blk_src};
        init_w[9]  = '0;
        init_w[10] = DIAG_C2;
        init_w[11] = key_low[31:0];
        init_w[12] = key_low[63:32];
        init_w[13] = key_high[31:0];
        init_w[14] = key_high[63:32];
        init_w[15] = DIAG_C3;
    end

    // shared adders: round steps add the quad operands, the final pass adds row 0 and init
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (state_reg == CORE_ADD) begin
                op_a[j] = st_reg[j];
                op_b[j] = init_w[{step_reg, 2'(j)}];
            end else begin
                op_a[j] = st_reg[quad_idx(j, 0)];
                op_b[j] = st_reg[quad_idx(j, 3)];
            end
            sum[j] = op_a[j] + op_b[j];
        end
    end

    // one step on every column quad, quad rotated so the wiring never changes
    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            stepped[i] = st_reg[i];
        end
        for (int j = 0; j < 4; j++) begin
            stepped[quad_idx(j, 0)] = st_reg[quad_idx(j, 1)] ^ qr_rot(sum[j], step_reg);
            stepped[quad_idx(j, 1)] = st_reg[quad_idx(j, 2)];
            stepped[quad_idx(j, 2)] = st_reg[quad_idx(j, 3)];
            stepped[quad_idx(j, 3)] = st_reg[quad_idx(j, 0)];
        end
    end

    always_comb begin
        state_next = state_reg;
        half_next  = half_reg;
        step_next  = step_reg;
        blk_next   = blk_reg;
        done_next  = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            st_next[i] = st_reg[i];
        end
        case (state_reg)
            CORE_IDLE: begin
                if (ctl.start) begin
                    blk_next   = ctl.blk_idx;
                    half_next  = '0;
                    step_next  = '0;
                    state_next = CORE_ROUND;
                    for (int i = 0; i < NUM_WORDS; i++) begin
                        st_next[i] = init_w[i];
                    end
                end
            end
            CORE_ROUND: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    // transpose at the end of each half round: row rounds become column rounds
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            st_next[4 * r + c] = stepped[4 * c + r];
                        end
                    end
                    if (half_reg == LAST_HALF) begin
                        half_next  = '0;
                        state_next = CORE_ADD;
                    end else begin
                        half_next = half_reg + HALF_CNT_W'(1);
                    end
                end else begin
                    for (int i = 0; i < NUM_WORDS; i++) begin
                        st_next[i] = stepped[i];
                    end
                end
            end
            CORE_ADD: begin
                // rows move up, finished row enters at the bottom
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        st_next[4 * r + c] = st_reg[4 * (r + 1) + c];
                    end
                end
                for (int c = 0; c < 4; c++) begin
                    st_next[12 + c] = sum[c];
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    done_next  = 1'b1;
                    state_next = CORE_IDLE;
                end
            end
            default: begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CORE_IDLE;
            half_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            half_reg  <= half_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        for (int i = 0; i < NUM_WORDS; i++) begin
            st_reg[i] <= st_next[i];
        end
    end

endmodule

// File: tb/sv/salsa_keystream_byte_xor_unit_tb.sv
// self-checking testbench for the salsa keystream byte xor unit
module salsa_keystream_byte_xor_unit_tb;
    import skx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int unsigned DOUBLE_ROUNDS = 10;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned TAIL_CYCLES   = 100;
    localparam int unsigned MAX_PRINTED   = 20;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } tx_byte_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } xored_byte_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_in;
    logic [POS_W-1:0]      s_byte_position;
    logic                  s_last_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [DATA_W-1:0]     m_data_out;
    logic                  m_last_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    tx_byte_t    tx_bytes_q[$];
    xored_byte_t xored_bytes_q[$];

    // shadow of the registers and the keystream cache
    logic [CFG_W-1:0]     key_lo;
    logic [CFG_W-1:0]     key_hi;
    logic [CFG_W-1:0]     nonce_pre;
    logic [7:0]           ks_cache [64];
    logic [BLK_IDX_W-1:0] ks_blk_idx;
    logic                 ks_filled;
    logic [31:0]          mix_w [16];

    logic in_taken;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   err_cnt;
    int   bytes_sent;
    int   results_seen;
    int   blocks_made;
    int   cfg_writes;
    int   idle_cycles;

    salsa_keystream_byte_xor_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_in       (s_data_in),
        .s_byte_position (s_byte_position),
        .s_last_in       (s_last_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_last_out      (m_last_out),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void quarter_mix(int a, int b, int c, int d);
        mix_w[b] = mix_w[b] ^ rotl32(mix_w[a] + mix_w[d], 7);
        mix_w[c] = mix_w[c] ^ rotl32(mix_w[b] + mix_w[a], 9);
        mix_w[d] = mix_w[d] ^ rotl32(mix_w[c] + mix_w[b], 13);
        mix_w[a] = mix_w[a] ^ rotl32(mix_w[d] + mix_w[c], 18);
    endfunction

    function automatic void regen_keystream(logic [BLK_IDX_W-1:0] blk);
        logic [31:0] init_w [16];
        logic [31:0] sum;
        int i;
        int k;
        init_w[0]  = DIAG_C0;
        init_w[5]  = DIAG_C1;
        init_w[10] = DIAG_C2;
        init_w[15] = DIAG_C3;
        init_w[1]  = key_lo[31:0];
        init_w[2]  = key_lo[63:32];
        init_w[3]  = key_hi[31:0];
        init_w[4]  = key_hi[63:32];
        init_w[6]  = nonce_pre[31:0];
        init_w[7]  = nonce_pre[63:32];
        init_w[8]  = 32'(blk);
        init_w[9]  = 32'd0;
        // 128-bit key is repeated in the second key slot
        for (i = 11; i < 15; i++) init_w[i] = init_w[i - 10];
        for (i = 0; i < 16; i++) mix_w[i] = init_w[i];
        for (i = 0; i < DOUBLE_ROUNDS; i++) begin
            quarter_mix(0, 4, 8, 12);
            quarter_mix(5, 9, 13, 1);
            quarter_mix(10, 14, 2, 6);
            quarter_mix(15, 3, 7, 11);
            quarter_mix(0, 1, 2, 3);
            quarter_mix(5, 6, 7, 4);
            quarter_mix(10, 11, 8, 9);
            quarter_mix(15, 12, 13, 14);
        end
        for (i = 0; i < 16; i++) begin
            sum = mix_w[i] + init_w[i];
            for (k = 0; k < 4; k++) ks_cache[4 * i + k] = sum[8 * k +: 8];
        end
    endfunction

    function automatic xored_byte_t cipher_byte(logic [DATA_W-1:0] d, logic [POS_W-1:0] p,
                                                logic l);
        logic [BLK_IDX_W-1:0] blk;
        xored_byte_t r;
        blk = p[POS_W-1:6];
        if (!ks_filled || blk != ks_blk_idx) begin
            regen_keystream(blk);
            ks_blk_idx = blk;
            ks_filled  = 1'b1;
            blocks_made++;
        end
        r.data = d ^ ks_cache[p[5:0]];
        r.last = l;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (err_cnt < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
        err_cnt++;
    endtask

    // config writes happen only while the unit is idle, shadow follows at once
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_KEY_LOW:      key_lo    = val;
            CFG_KEY_HIGH:     key_hi    = val;
            CFG_NONCE_PREFIX: nonce_pre = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(logic [CFG_W-1:0] klo, logic [CFG_W-1:0] khi,
                                  logic [CFG_W-1:0] np);
        write_reg(CFG_KEY_LOW, klo);
        write_reg(CFG_KEY_HIGH, khi);
        write_reg(CFG_NONCE_PREFIX, np);
        write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
    endtask

    task automatic wait_drained();
        while (tx_bytes_q.size() != 0 || s_valid || xored_bytes_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_byte(logic [DATA_W-1:0] d, logic [POS_W-1:0] p, logic l);
        tx_byte_t t;
        t.data = d;
        t.pos  = p;
        t.last = l;
        tx_bytes_q.push_back(t);
    endtask

    // mostly buffers of consecutive positions, some jumps, revisits and stray bytes
    task automatic queue_random_bytes(int n);
        logic [POS_W-1:0] p;
        int left;
        int run;
        int k;
        p    = $urandom;
        left = n;
        while (left > 0) begin
            case ($urandom_range(9))
                0: p = $urandom;
                1: p = 32'hFFFF_FFFF - $urandom_range(80);
                2: p = p - $urandom_range(70);
                3: begin
                    queue_byte(DATA_W'($urandom), $urandom, 1'($urandom_range(1)));
                    left--;
                    continue;
                end
                default: ;
            endcase
            run = $urandom_range(48, 1);
            if (run > left) run = left;
            for (k = 0; k < run; k++) begin
                queue_byte(DATA_W'($urandom), p, k == run - 1);
                p++;
            end
            left -= run;
        end
    endtask

    always @(negedge aclk) begin : drive_bytes
        tx_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (tx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = tx_bytes_q.pop_front();
                s_data_in       <= nxt.data;
                s_byte_position <= nxt.pos;
                s_last_in       <= nxt.last;
                s_valid         <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // results are checked before the new transaction is predicted
    always @(posedge aclk) begin : watch_channels
        xored_byte_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (xored_bytes_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data %02h last %0b",
                                              m_data_out, m_last_out));
                end else begin
                    want = xored_bytes_q.pop_front();
                    if (m_data_out !== want.data)
                        report_mismatch($sformatf("data_out %02h, wanted %02h",
                                                  m_data_out, want.data));
                    if (m_last_out !== want.last)
                        report_mismatch($sformatf("last_out %0b, wanted %0b",
                                                  m_last_out, want.last));
                    results_seen++;
                end
            end
            if (s_valid && s_ready) begin
                xored_bytes_q.push_back(cipher_byte(s_data_in, s_byte_position, s_last_in));
                bytes_sent++;
            end
            in_taken <= s_valid && s_ready;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data_in       = '0;
        s_byte_position = '0;
        s_last_in       = 1'b0;
        m_ready         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_taken        = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        err_cnt         = 0;
        bytes_sent      = 0;
        results_seen    = 0;
        blocks_made     = 0;
        cfg_writes      = 0;
        idle_cycles     = 0;
        key_lo          = '0;
        key_hi          = '0;
        nonce_pre       = '0;
        ks_blk_idx      = '0;
        ks_filled       = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // phase 0: no idling, all-zero registers, then directed corners and random bytes
        write_all_regs('0, '0, '0);
        // block 0 is the reset index but the cache is still empty
        queue_byte(8'h00, 32'h0000_0000, 1'b0);
        queue_byte(8'hFF, 32'h0000_003F, 1'b1);
        queue_byte(8'hA5, 32'h0000_0040, 1'b0);
        queue_byte(8'h5A, 32'hFFFF_FFFF, 1'b1);
        queue_byte(8'hFF, 32'hFFFF_FFC0, 1'b0);
        queue_byte(8'h00, 32'h0000_0000, 1'b0);
        queue_byte(8'h3C, 32'h0000_0005, 1'b1);
        wait_drained();
        // new key must not flush the cached block
        write_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_SPARE_IDX, '1);
        queue_byte(8'hC3, 32'h0000_0007, 1'b0);
        queue_byte(8'h81, 32'h0000_0080, 1'b0);
        queue_byte(8'h7E, 32'h0000_0007, 1'b1);
        queue_byte(8'h55, 32'h5555_5555, 1'b0);
        queue_byte(8'hAA, 32'hAAAA_AAAA, 1'b1);
        queue_byte(8'h01, 32'h5555_5556, 1'b0);
        queue_random_bytes(110);
        wait_drained();

        // phase 1: sender idle, all-one registers
        write_all_regs('1, '1, '1);
        send_idle_pct  = 63;
        recv_stall_pct = 0;
        queue_random_bytes(125);
        wait_drained();

        // phase 2: receiver stalling, random registers
        send_idle_pct  = 0;
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        recv_stall_pct = 63;
        queue_random_bytes(125);
        wait_drained();

        // phase 3: both sides idling, sender holds off halfway until all results are back
        write_all_regs({$urandom, $urandom}, '1, {$urandom, $urandom});
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        queue_random_bytes(60);
        wait_drained();
        queue_random_bytes(65);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (xored_bytes_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", xored_bytes_q.size()));
        $display("covered %0d bytes and %0d results over %0d keystream blocks,",
                 bytes_sent, results_seen, blocks_made);
        $display("%0d register writes, four idle and stall mixes", cfg_writes);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/skx_pkg.sv
rtl/core/skx_core.sv
rtl/core/salsa_keystream_byte_xor_unit.sv
tb/sv/salsa_keystream_byte_xor_unit_tb.sv
